>>> hw/rtl/svs_pkg.sv
// ----------------------------------------------------------------------------
// svs_pkg - shared definitions for the sample variance / std dev block
// Widths, iteration counts, the multiply-accumulate op codes, the sequencer
// state types and the status bundle of the divide / root unit.
// ----------------------------------------------------------------------------
`default_nettype none

package svs_pkg;

	// sample stream
	localparam int SAMPLE_W    = 16;
	localparam int MAX_COUNT   = 65536;
	localparam int CNT_W       = 17;
	localparam int MAG_W       = 16;

	// accumulators
	localparam int SUM_W       = 33;
	localparam int SQSUM_W     = 47;
	localparam int SMAG_W      = 32;

	// multiply-accumulate unit
	localparam int OPD_W       = 32;
	localparam int D_W         = 2 * OPD_W;
	localparam int SQ_SPLIT    = 24;
	localparam int N2_W        = 33;

	// divide / root unit
	localparam int FRAC_SHIFT  = 16;
	localparam int NUM_W       = D_W + FRAC_SHIFT;
	localparam int DIV_ITERS   = NUM_W;
	localparam int ITER_W      = $clog2(DIV_ITERS);
	localparam int QUO_W       = 47;
	localparam int ROOT_ITERS  = (QUO_W + 1) / 2;
	localparam int ROOT_CNT_W  = $clog2(ROOT_ITERS);
	localparam int POS_W       = $clog2(QUO_W);
	localparam int SUB_W       = QUO_W + 1;

	// result fields
	localparam int VAR_W       = 38;
	localparam int VAR_LSB     = 8;
	localparam int STD_W       = 23;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 80;
	localparam int OUT_PAD_W   = OUT_TDATA_W - (VAR_W + STD_W + CNT_W);

	typedef enum logic [1:0] {
		MAC_ADD,
		MAC_ADD_HI,
		MAC_SUB
	} mac_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_MUL_SUB,
		ST_MUL_N2,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_OUT
	} ctrl_state_t;

	typedef enum logic [2:0] {
		DS_IDLE,
		DS_DIV,
		DS_ROOT_INIT,
		DS_ROOT,
		DS_DONE
	} ds_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} ds_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/svs_mac.sv
// ----------------------------------------------------------------------------
// svs_mac - shared multiply-accumulate unit
// One 32x32 multiplier followed by a 64-bit add or subtract, with an optional
// left shift of the product for the upper partial product.
// ----------------------------------------------------------------------------
`default_nettype none

module svs_mac import svs_pkg::*; (
	input  mac_op_t          op,
	input  logic [OPD_W-1:0] a,
	input  logic [OPD_W-1:0] b,
	input  logic [D_W-1:0]   acc,
	output logic [D_W-1:0]   res
);

	logic [D_W-1:0] prod;
	logic [D_W-1:0] addend;

	// single multiplier
	assign prod = a * b;

	// accumulate
	always_comb begin
		addend = prod;
		res    = acc + prod;
		case (op)
			MAC_ADD: begin
				addend = prod;
				res    = acc + addend;
			end
			MAC_ADD_HI: begin
				addend = prod << SQ_SPLIT;
				res    = acc + addend;
			end
			MAC_SUB: begin
				addend = prod;
				res    = acc - addend;
			end
			default: begin
				addend = prod;
				res    = acc + addend;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> hw/rtl/svs_divsqrt.sv
// ----------------------------------------------------------------------------
// svs_divsqrt - iterative divider and square root on one subtractor
// Restoring division of (d << 16) by n2, one quotient bit a cycle, then a
// digit-by-digit integer square root of the quotient, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module svs_divsqrt import svs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [D_W-1:0]   d,
	input  logic [N2_W-1:0]  n2,
	output ds_status_t       status,
	output logic [QUO_W-1:0] quo,
	output logic [QUO_W-1:0] root
);

	ds_state_t          state_q, state_nxt;
	logic [ITER_W-1:0]  cnt_q;
	logic [NUM_W-1:0]   num_q;
	logic [N2_W-1:0]    div_q;
	logic [QUO_W-1:0]   rem_q;
	logic [QUO_W-1:0]   quo_q;
	logic [QUO_W-1:0]   root_q;

	logic [N2_W:0]      r_shift;
	logic [POS_W-1:0]   bit_pos;
	logic [QUO_W-1:0]   root_bit;
	logic [SUB_W-1:0]   sub_a;
	logic [SUB_W-1:0]   sub_b;
	logic [SUB_W:0]     diff;
	logic               ge;

	// partial remainder with next numerator bit shifted in
	assign r_shift = {rem_q[N2_W-1:0], num_q[NUM_W-1]};

	// root trial bit walks down two places a step
	assign bit_pos  = POS_W'(QUO_W - 1) - POS_W'({cnt_q[ROOT_CNT_W-1:0], 1'b0});
	assign root_bit = QUO_W'(1) << bit_pos;

	// shared compare-subtract
	always_comb begin
		if (state_q == DS_DIV) begin
			sub_a = SUB_W'(r_shift);
			sub_b = SUB_W'(div_q);
		end else begin
			sub_a = SUB_W'(rem_q);
			sub_b = SUB_W'(root_q) + SUB_W'(root_bit);
		end
	end
	assign diff = {1'b0, sub_a} - {1'b0, sub_b};
	assign ge   = ~diff[SUB_W];

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			DS_IDLE:      if (start) state_nxt = DS_DIV;
			DS_DIV:       if (cnt_q == ITER_W'(DIV_ITERS - 1)) state_nxt = DS_ROOT_INIT;
			DS_ROOT_INIT: state_nxt = DS_ROOT;
			DS_ROOT:      if (cnt_q == ITER_W'(ROOT_ITERS - 1)) state_nxt = DS_DONE;
			DS_DONE:      state_nxt = DS_IDLE;
			default:      state_nxt = DS_IDLE;
		endcase
	end

	// status outputs
	always_comb begin
		status.busy = (state_q != DS_IDLE);
		status.done = (state_q == DS_DONE);
		quo         = quo_q;
		root        = root_q;
	end

	// state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DS_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			case (state_q)
				DS_IDLE:      cnt_q <= '0;
				DS_DIV:       cnt_q <= (state_nxt == DS_DIV) ? cnt_q + 1'b1 : '0;
				DS_ROOT_INIT: cnt_q <= '0;
				DS_ROOT:      cnt_q <= cnt_q + 1'b1;
				default:      cnt_q <= '0;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			DS_IDLE: if (start) begin
				num_q <= {d, FRAC_SHIFT'(0)};
				div_q <= n2;
				rem_q <= '0;
				quo_q <= '0;
			end
			DS_DIV: begin
				num_q <= num_q << 1;
				rem_q <= ge ? QUO_W'(diff[N2_W:0]) : QUO_W'(r_shift);
				quo_q <= {quo_q[QUO_W-2:0], ge};
			end
			DS_ROOT_INIT: begin
				rem_q  <= quo_q;
				root_q <= '0;
			end
			DS_ROOT: begin
				if (ge) begin
					rem_q  <= diff[QUO_W-1:0];
					root_q <= (root_q >> 1) + root_bit;
				end else begin
					root_q <= root_q >> 1;
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

>>> hw/rtl/sample_variance_stddev.sv
// ----------------------------------------------------------------------------
// sample_variance_stddev - population variance and standard deviation
// Accumulates signed samples and, on the sample marked tlast, returns the
// variance and its square root, both unsigned with 8 fraction bits.
// ----------------------------------------------------------------------------
// Each counted sample is added into a running sum, sum of squares and count;
// it is transferred, then squared through the shared multiplier before the
// next sample is taken. A sample past 65536 in one run is dropped unsquared
// and sets the overflow flag. The sample marked tlast starts the result: four
// passes of the shared 32x32 multiply-accumulate build n*sumsq - sum^2 and
// n^2, then an 80-step restoring divide and a 24-step square root on one
// shared compare-subtract unit give the result. s_tready stays low from the
// transfer of the tlast sample until the result is loaded into the output
// register, so longer while the previous result still waits. The result
// waits in an output register; new samples are taken while it is pending,
// but the next result only leaves the sequencer once the previous one is
// transferred. All accumulators clear when the result is loaded.
`default_nettype none

module sample_variance_stddev import svs_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [15:0] sample
	input  logic                   s_tlast,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [37:0] variance_q8, [60:38] std_dev_q8,
	                                          // [77:61] sample_count, [79:78] zero
	output logic                   m_tuser    // [0] overflow
);

	ctrl_state_t              state_q, state_nxt;

	// accumulators
	logic signed [SUM_W-1:0]  sum_q;
	logic [SQSUM_W-1:0]       sumsq_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     ovf_q;
	logic                     last_q;
	logic [MAG_W-1:0]         mag_q;

	// result working registers
	logic [D_W-1:0]           d_q;
	logic [N2_W-1:0]          n2_q;

	// output register
	logic                     m_tvalid_q;
	logic [VAR_W-1:0]         var_q;
	logic [STD_W-1:0]         std_q;
	logic [CNT_W-1:0]         cnt_out_q;
	logic                     ovf_out_q;

	logic                     in_xfer;
	logic                     counted;
	logic [MAG_W-1:0]         in_mag;
	logic [SMAG_W-1:0]        smag;
	logic                     out_free;
	logic                     out_load;
	logic                     ds_start;
	ds_status_t               ds_status;
	logic [QUO_W-1:0]         ds_quo;
	logic [QUO_W-1:0]         ds_root;

	mac_op_t                  mac_op;
	logic [OPD_W-1:0]         mac_a;
	logic [OPD_W-1:0]         mac_b;
	logic [D_W-1:0]           mac_acc;
	logic [D_W-1:0]           mac_res;
	logic [2*STD_W-1:0]       std_sq;

	assign in_xfer  = s_tvalid && s_tready;
	assign counted  = (cnt_q != CNT_W'(MAX_COUNT));
	assign in_mag   = s_tdata[SAMPLE_W-1] ? MAG_W'(~s_tdata + 1'b1) : MAG_W'(s_tdata);
	assign smag     = sum_q[SUM_W-1] ? SMAG_W'(-sum_q) : SMAG_W'(sum_q);
	assign out_free = !m_tvalid_q || m_tready;

	// shared multiply-accumulate
	svs_mac u_mac (
		.op  (mac_op),
		.a   (mac_a),
		.b   (mac_b),
		.acc (mac_acc),
		.res (mac_res)
	);

	// divide and root
	svs_divsqrt u_divsqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ds_start),
		.d      (d_q),
		.n2     (n2_q),
		.status (ds_status),
		.quo    (ds_quo),
		.root   (ds_root)
	);

	// sequencer next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (counted)      state_nxt = ST_SQUARE;
					else if (s_tlast) state_nxt = ST_MUL_LO;
				end
			end
			ST_SQUARE:   state_nxt = last_q ? ST_MUL_LO : ST_IDLE;
			ST_MUL_LO:   state_nxt = ST_MUL_HI;
			ST_MUL_HI:   state_nxt = ST_MUL_SUB;
			ST_MUL_SUB:  state_nxt = ST_MUL_N2;
			ST_MUL_N2:   state_nxt = ST_DIV_GO;
			ST_DIV_GO:   state_nxt = ST_DIV_WAIT;
			ST_DIV_WAIT: if (ds_status.done) state_nxt = ST_OUT;
			ST_OUT:      if (out_free) state_nxt = ST_IDLE;
			default:     state_nxt = ST_IDLE;
		endcase
	end

	// sequencer outputs and multiplier operand select
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		ds_start = (state_q == ST_DIV_GO);
		out_load = (state_q == ST_OUT) && out_free;
		mac_op   = MAC_ADD;
		mac_a    = '0;
		mac_b    = '0;
		mac_acc  = '0;
		case (state_q)
			ST_SQUARE: begin
				mac_a   = OPD_W'(mag_q);
				mac_b   = OPD_W'(mag_q);
				mac_acc = D_W'(sumsq_q);
			end
			ST_MUL_LO: begin
				mac_a = OPD_W'(cnt_q);
				mac_b = OPD_W'(sumsq_q[SQ_SPLIT-1:0]);
			end
			ST_MUL_HI: begin
				mac_op  = MAC_ADD_HI;
				mac_a   = OPD_W'(cnt_q);
				mac_b   = OPD_W'(sumsq_q[SQSUM_W-1:SQ_SPLIT]);
				mac_acc = d_q;
			end
			ST_MUL_SUB: begin
				mac_op  = MAC_SUB;
				mac_a   = OPD_W'(smag);
				mac_b   = OPD_W'(smag);
				mac_acc = d_q;
			end
			ST_MUL_N2: begin
				mac_a = OPD_W'(cnt_q);
				mac_b = OPD_W'(cnt_q);
			end
			default: ;
		endcase
	end

	// control state and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			sum_q      <= '0;
			sumsq_q    <= '0;
			cnt_q      <= '0;
			ovf_q      <= 1'b0;
			last_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (in_xfer) begin
				last_q <= s_tlast;
				if (counted) begin
					sum_q <= sum_q + SUM_W'(signed'(s_tdata[SAMPLE_W-1:0]));
					cnt_q <= cnt_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (state_q == ST_SQUARE)
				sumsq_q <= mac_res[SQSUM_W-1:0];
			if (out_load) begin
				sum_q   <= '0;
				sumsq_q <= '0;
				cnt_q   <= '0;
				ovf_q   <= 1'b0;
			end
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// working and output payload registers
	always_ff @(posedge clk) begin
		if (in_xfer)
			mag_q <= in_mag;
		case (state_q)
			ST_MUL_LO:  d_q  <= mac_res;
			ST_MUL_HI:  d_q  <= mac_res;
			ST_MUL_SUB: d_q  <= mac_res;
			ST_MUL_N2:  n2_q <= mac_res[N2_W-1:0];
			default: ;
		endcase
		if (out_load) begin
			var_q     <= ds_quo[VAR_LSB+VAR_W-1:VAR_LSB];
			std_q     <= ds_root[STD_W-1:0];
			cnt_out_q <= cnt_q;
			ovf_out_q <= ovf_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{OUT_PAD_W{1'b0}}, cnt_out_q, std_q, var_q};
	assign m_tuser  = ovf_out_q;

	// checks
	assign std_sq = std_q * std_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_COUNT))
		else $error("sample count past maximum");

	a_root_vs_var: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> (VAR_W'(std_sq >> VAR_LSB) <= var_q))
		else $error("square of std dev exceeds variance");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && ovf_out_q) |-> (cnt_out_q == CNT_W'(MAX_COUNT)))
		else $error("overflow flagged on a run that was not full");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !ds_status.busy)
		else $error("divide unit busy while sequencer idle");

endmodule

`default_nettype wire

>>> tb/sv/sample_variance_stddev_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_variance_stddev_test - self-checking bench for the variance block
// Streams runs of signed samples into the block and predicts every result
// (variance, std dev, count, overflow) in integer arithmetic. A scoreboard
// holds the expected results in order and checks each output transfer.
// ----------------------------------------------------------------------------

import svs_pkg::*;

typedef struct {
	logic [VAR_W-1:0] variance_q8;
	logic [STD_W-1:0] std_dev_q8;
	logic [CNT_W-1:0] sample_count;
	logic             overflow;
} stats_result_t;

// running statistics and the queue of results still to come
class variance_scoreboard;
	longint signed   acc_sum;
	longint unsigned acc_sqsum;
	int unsigned     acc_count;
	bit              acc_ovf;
	stats_result_t   pending[$];
	int unsigned     errors;

	function new();
		clear_run();
		errors = 0;
	endfunction

	function void clear_run();
		acc_sum   = 0;
		acc_sqsum = 0;
		acc_count = 0;
		acc_ovf   = 1'b0;
	endfunction

	// bitwise integer square root, floor
	function longint unsigned int_sqrt(longint unsigned x);
		longint unsigned root;
		longint unsigned cand;
		root = 0;
		for (int b = 31; b >= 0; b--) begin
			cand = root | (64'd1 << b);
			if (cand * cand <= x)
				root = cand;
		end
		return root;
	endfunction

	// fold one accepted sample into the run; a last sample queues a result
	function void note_sample(logic [SAMPLE_W-1:0] raw, logic last);
		longint signed   x;
		longint unsigned mag, smag, n, n2, d, q, r, var_q8, sd_q8;
		stats_result_t   res;
		x = {{(64 - SAMPLE_W){raw[SAMPLE_W-1]}}, raw};
		if (acc_count < MAX_COUNT) begin
			mag = (x < 0) ? -x : x;
			acc_sum   += x;
			acc_sqsum += mag * mag;
			acc_count++;
		end else begin
			acc_ovf = 1'b1;
		end
		if (!last)
			return;
		n      = acc_count;
		var_q8 = 0;
		sd_q8  = 0;
		if (n != 0) begin
			smag   = (acc_sum < 0) ? -acc_sum : acc_sum;
			d      = n * acc_sqsum - smag * smag;
			n2     = n * n;
			q      = d / n2;
			r      = d % n2;
			var_q8 = q * 256 + (r * 256) / n2;
			sd_q8  = int_sqrt(q * 65536 + (r * 65536) / n2);
		end
		res.variance_q8  = var_q8[VAR_W-1:0];
		res.std_dev_q8   = sd_q8[STD_W-1:0];
		res.sample_count = n[CNT_W-1:0];
		res.overflow     = acc_ovf;
		pending.push_back(res);
		clear_run();
	endfunction

	function void compare_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	// compare one output transfer with the oldest expected result
	function void check_result(logic [OUT_TDATA_W-1:0] tdata, logic tuser);
		stats_result_t want;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual tdata %h tuser %b",
				$time, tdata, tuser);
			errors++;
			return;
		end
		want = pending.pop_front();
		compare_field("variance_q8", want.variance_q8, tdata[VAR_W-1:0]);
		compare_field("std_dev_q8", want.std_dev_q8, tdata[VAR_W +: STD_W]);
		compare_field("sample_count", want.sample_count, tdata[VAR_W+STD_W +: CNT_W]);
		compare_field("padding", 0, tdata[OUT_TDATA_W-1 -: OUT_PAD_W]);
		compare_field("overflow", want.overflow, tuser);
	endfunction
endclass

module sample_variance_stddev_test;

	localparam int RANDOM_ITEMS    = 1100;
	localparam int QUIET_ITEMS     = 100;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int STALL_LIMIT     = 5000;
	localparam int DRAIN_CYCLES    = 300;

	typedef enum int {
		FILL_FULL,
		FILL_SMALL,
		FILL_EXTREME,
		FILL_HIGH
	} fill_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;   // [15:0] sample
	logic                   s_tlast;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;   // [37:0] variance_q8, [60:38] std_dev_q8,
	                                   // [77:61] sample_count, [79:78] zero
	logic                   m_tuser;   // [0] overflow

	variance_scoreboard sb;
	bit          idle_on      = 1'b0;
	bit          hold_off_req = 1'b0;
	int unsigned stall_cycles = 0;

	always #5 clk = ~clk;

	sample_variance_stddev u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// output transfer check
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
	end

	// receiver: random back-pressure and one long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
				m_tready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic pause_input(int cycles);
		s_tvalid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// offer one sample and hold it until the transfer
	task automatic send_sample(logic [SAMPLE_W-1:0] value, logic last);
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		sb.note_sample(value, last);
		if (idle_on && $urandom_range(0, 5) == 0)
			pause_input($urandom_range(1, 19));
	endtask

	// stop offering until every queued result has been seen
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending.size() != 0);
	endtask

	function automatic logic [SAMPLE_W-1:0] pick_sample(fill_t fill);
		case (fill)
			FILL_SMALL:   return SAMPLE_W'($urandom_range(0, 16) - 8);
			FILL_EXTREME: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
			FILL_HIGH:    return SAMPLE_W'(16'h7ff0 + $urandom_range(0, 15));
			default:      return SAMPLE_W'($urandom_range(0, 65535));
		endcase
	endfunction

	// one run of samples, the final one marked last
	task automatic send_run(int len, fill_t fill);
		for (int i = 0; i < len; i++)
			send_sample(pick_sample(fill), i == len - 1);
	endtask

	task automatic send_random_runs(int items);
		int sent;
		int len;
		sent = 0;
		while (sent < items) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 300) : $urandom_range(1, 32);
			send_run(len, fill_t'($urandom_range(0, 3)));
			sent += len;
		end
	endtask

	initial begin
		sb       = new();
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tlast  = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: single-sample runs at the extremes
		send_sample(16'h7fff, 1'b1);
		send_sample(16'h8000, 1'b1);
		send_sample(16'h0000, 1'b1);
		// widest spread of two samples
		send_sample(16'h8000, 1'b0);
		send_sample(16'h7fff, 1'b1);
		// small ramp, fractional variance
		send_sample(16'h0001, 1'b0);
		send_sample(16'h0002, 1'b0);
		send_sample(16'h0003, 1'b0);
		send_sample(16'h0004, 1'b1);
		// zero mean
		send_sample(16'hffff, 1'b0);
		send_sample(16'h0001, 1'b1);
		// constant negative extreme, no spread
		send_sample(16'h8000, 1'b0);
		send_sample(16'h8000, 1'b0);
		send_sample(16'h8000, 1'b1);
		// uneven mix of extremes
		send_sample(16'h7fff, 1'b0);
		send_sample(16'h7fff, 1'b0);
		send_sample(16'h8000, 1'b1);
		// all-ones and alternating bit patterns
		send_sample(16'haaaa, 1'b0);
		send_sample(16'h5555, 1'b0);
		send_sample(16'h0000, 1'b0);
		send_sample(16'hffff, 1'b1);
		wait_drained();

		// random runs with idling on both sides
		idle_on = 1'b1;
		send_random_runs(300);

		// long receiver hold-off while the input keeps offering runs
		idle_on      = 1'b0;
		hold_off_req = 1'b1;
		for (int i = 0; i < 20; i++)
			send_run($urandom_range(1, 3), FILL_FULL);
		idle_on = 1'b1;
		send_random_runs(200);

		// sender waits for every result before going on
		wait_drained();
		send_random_runs(RANDOM_ITEMS - QUIET_ITEMS - 500);

		// closing stretch without idling
		idle_on = 1'b0;
		wait_drained();
		send_random_runs(QUIET_ITEMS);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending.size() != 0) begin
			$display("%0t: results never arrived, expected %0d more, actual 0",
				$time, sb.pending.size());
			sb.errors++;
		end
		if (sb.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
